// File: rtl/core/assert_macros.svh
// Assertion macros used by the scheduler top level.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define SRTF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define SRTF_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/srtf_pkg.sv
// Shared types and constants for the shortest-remaining-time-first scheduler.
// No dependencies; imported by every module of the block.
package srtf_pkg;

  localparam int MAX_PROC_DEF = 16;
  localparam int ARR_W        = 10;
  localparam int BUR_W        = 8;
  localparam int COMP_W       = 13;
  localparam int TAT_W        = 12;
  localparam int NUM_W        = 5;
  localparam int ARR_SPAN     = 1 << ARR_W;
  localparam int BURST_MAX    = (1 << BUR_W) - 1;
  localparam int IDX_W_DEF    = (MAX_PROC_DEF > 1) ? $clog2(MAX_PROC_DEF) : 1;
  localparam int TICK_W_DEF   = $clog2(ARR_SPAN + MAX_PROC_DEF * BURST_MAX);

  localparam logic MODE_SIM = 1'b0;
  localparam logic MODE_OUT = 1'b1;

  localparam logic [TAT_W-1:0] TAT_SAT = {TAT_W{1'b1}};

  typedef struct packed {
    logic [ARR_W-1:0] arrival_time;
    logic [BUR_W-1:0] burst_time;
    logic             last_job;
  } in_item_t;

  typedef struct packed {
    logic [NUM_W-1:0]  job_number;
    logic [ARR_W-1:0]  job_arrival;
    logic [BUR_W-1:0]  job_burst;
    logic [COMP_W-1:0] completion_time;
    logic [TAT_W-1:0]  turnaround_time;
    logic [TAT_W-1:0]  waiting_time;
    logic              last_result;
  } out_item_t;

  typedef struct packed {
    logic [ARR_W-1:0]  arr;
    logic [BUR_W-1:0]  bur;
    logic [BUR_W-1:0]  rem;
    logic [COMP_W-1:0] fin;
  } entry_t;

  typedef struct packed {
    logic             found;
    entry_t           ent;
    logic             nxt_found;
    logic [ARR_W-1:0] nxt_arr;
  } sel_res_t;

endpackage

// File: rtl/core/srtf_mem.sv
// Job table memory: one write port, one read port with registered data.
// Depends on srtf_pkg for the entry type.
module srtf_mem import srtf_pkg::*; #(
  parameter int DEPTH = MAX_PROC_DEF,
  parameter int IDX_W = IDX_W_DEF
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/srtf_sel.sv
// Running selector that takes one job table entry per cycle while cand_vld is high.
// Depends on srtf_pkg; tracks the best candidate and the next arrival.
module srtf_sel import srtf_pkg::*; #(
  parameter int IDX_W  = IDX_W_DEF,
  parameter int TICK_W = TICK_W_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  logic              mode,
  input  logic              cand_vld,
  input  logic [IDX_W-1:0]  cand_idx,
  input  entry_t            cand_ent,
  input  logic              cand_done,
  input  logic [TICK_W-1:0] now,
  output sel_res_t          res,
  output logic [IDX_W-1:0]  best_idx
);

  logic             found_r, nxt_found_r;
  entry_t           ent_r;
  logic [IDX_W-1:0] idx_r;
  logic [ARR_W-1:0] nxt_arr_r;
  logic             ready, elig, better, nxt_elig, nxt_better;

  assign ready = TICK_W'(cand_ent.arr) <= now;

  always_comb begin
    if (mode == MODE_SIM) begin
      elig     = !cand_done && ready;
      better   = !found_r || (cand_ent.rem < ent_r.rem) ||
                 ((cand_ent.rem == ent_r.rem) && (cand_ent.arr < ent_r.arr));
      nxt_elig = !cand_done && !ready;
    end else begin
      elig     = cand_done;
      better   = !found_r || (cand_ent.arr < ent_r.arr);
      nxt_elig = 1'b0;
    end
    nxt_better = !nxt_found_r || (cand_ent.arr < nxt_arr_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= 1'b0;
      nxt_found_r <= 1'b0;
    end else if (clr) begin
      found_r     <= 1'b0;
      nxt_found_r <= 1'b0;
    end else if (cand_vld) begin
      if (elig && better) begin
        found_r <= 1'b1;
      end
      if (nxt_elig && nxt_better) begin
        nxt_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cand_vld && !clr) begin
      if (elig && better) begin
        ent_r <= cand_ent;
        idx_r <= cand_idx;
      end
      if (nxt_elig && nxt_better) begin
        nxt_arr_r <= cand_ent.arr;
      end
    end
  end

  assign res.found     = found_r;
  assign res.ent       = ent_r;
  assign res.nxt_found = nxt_found_r;
  assign res.nxt_arr   = nxt_arr_r;
  assign best_idx      = idx_r;

endmodule

// File: rtl/core/srtf_batch_scheduler_top.sv
// Top level of the shortest-remaining-time-first batch scheduler.
// Depends on srtf_pkg, srtf_mem, srtf_sel and assert_macros.svh.
//
//   Channel   Direction  Handshake          Payload
//   in_*      input      in_valid/in_stall  in_item_t: arrival, burst, last job
//   out_*     output     out_valid/out_stall out_item_t: one result per job
//
// Loading takes a new job whenever in_valid is high. The final job starts the schedule, which
// runs event by event: each event scans the job table at one entry per cycle
// through its single read port, and there are at most 2N events for N jobs.
// Each result then needs its own scan of the job table.
// Reset is synchronous and needs no clearing pass; the done flags are flops.
// Input is stalled from the final job until the last result is registered.
`include "assert_macros.svh"

module srtf_batch_scheduler_top import srtf_pkg::*; #(
  parameter int MAX_PROCESSES = MAX_PROC_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int IDX_W  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);
  localparam int TICK_W = $clog2(ARR_SPAN + MAX_PROCESSES * BURST_MAX);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_OSCAN = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]               state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [CNT_W-1:0]         fin_cnt_r, fin_cnt_nxt;
  logic [IDX_W-1:0]         scan_r, scan_nxt;
  logic                     iss_on_r, iss_on_nxt;
  logic                     cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]         cmp_idx_r, cmp_idx_nxt;
  logic                     cmp_last_r, cmp_last_nxt;
  logic [TICK_W-1:0]        now_r, now_nxt;
  logic [MAX_PROCESSES-1:0] done_r, done_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  entry_t           mem_rdata;
  logic             sel_clr;
  logic             sel_mode;
  sel_res_t         sel_res;
  logic [IDX_W-1:0] best_idx;

  logic [TICK_W-1:0] gap;
  logic [BUR_W-1:0]  run;
  logic [BUR_W-1:0]  new_rem;
  logic [TICK_W-1:0] now_run;
  logic [BUR_W-1:0]  load_bur;
  logic [COMP_W-1:0] tat_full, wt_full;
  logic              scanning;

  srtf_mem #(
    .DEPTH (MAX_PROCESSES),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (scan_r),
    .rdata (mem_rdata)
  );

  srtf_sel #(
    .IDX_W  (IDX_W),
    .TICK_W (TICK_W)
  ) u_sel (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (sel_clr),
    .mode      (sel_mode),
    .cand_vld  (cmp_vld_r),
    .cand_idx  (cmp_idx_r),
    .cand_ent  (mem_rdata),
    .cand_done (done_r[cmp_idx_r]),
    .now       (now_r),
    .res       (sel_res),
    .best_idx  (best_idx)
  );

  assign sel_mode = (state_r == S_OSCAN) ? MODE_OUT : MODE_SIM;
  assign scanning = (state_r == S_SCAN) || (state_r == S_OSCAN);
  assign load_bur = (in_data.burst_time == '0) ? BUR_W'(1) : in_data.burst_time;

  // A job runs until it finishes or until the next arrival, whichever is first.
  assign gap     = TICK_W'(sel_res.nxt_arr) - now_r;
  assign run     = (sel_res.nxt_found && (gap < TICK_W'(sel_res.ent.rem))) ?
                   gap[BUR_W-1:0] : sel_res.ent.rem;
  assign new_rem = sel_res.ent.rem - run;
  assign now_run = now_r + TICK_W'(run);

  assign tat_full = (sel_res.ent.fin >= COMP_W'(sel_res.ent.arr)) ?
                    sel_res.ent.fin - COMP_W'(sel_res.ent.arr) : '0;
  assign wt_full  = (tat_full >= COMP_W'(sel_res.ent.bur)) ?
                    tat_full - COMP_W'(sel_res.ent.bur) : '0;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    fin_cnt_nxt   = fin_cnt_r;
    scan_nxt      = scan_r;
    iss_on_nxt    = iss_on_r;
    now_nxt       = now_r;
    done_nxt      = done_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = scan_r;
    cmp_last_nxt  = 1'b0;
    sel_clr       = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r[IDX_W-1:0];
    mem_wdata     = '0;

    if (scanning && iss_on_r) begin
      cmp_vld_nxt  = 1'b1;
      cmp_last_nxt = (CNT_W'(scan_r) + CNT_W'(1)) == cnt_r;
      sel_clr      = (scan_r == '0);
      if (cmp_last_nxt) begin
        iss_on_nxt = 1'b0;
      end else begin
        scan_nxt = scan_r + IDX_W'(1);
      end
    end

    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (cnt_r < CNT_W'(MAX_PROCESSES)) begin
            mem_we        = 1'b1;
            mem_wdata.arr = in_data.arrival_time;
            mem_wdata.bur = load_bur;
            mem_wdata.rem = load_bur;
            cnt_nxt       = cnt_r + CNT_W'(1);
          end
          if (in_data.last_job) begin
            state_nxt   = S_SCAN;
            scan_nxt    = '0;
            iss_on_nxt  = 1'b1;
            now_nxt     = '0;
            fin_cnt_nxt = '0;
          end
        end
      end
      S_SCAN: begin
        if (cmp_vld_r && cmp_last_r) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        scan_nxt   = '0;
        iss_on_nxt = 1'b1;
        state_nxt  = S_SCAN;
        if (sel_res.found) begin
          mem_we        = 1'b1;
          mem_waddr     = best_idx;
          mem_wdata     = sel_res.ent;
          mem_wdata.rem = new_rem;
          mem_wdata.fin = COMP_W'(now_run);
          now_nxt       = now_run;
          if (new_rem == '0) begin
            done_nxt[best_idx] = 1'b1;
            if ((fin_cnt_r + CNT_W'(1)) == cnt_r) begin
              state_nxt   = S_OSCAN;
              fin_cnt_nxt = '0;
            end else begin
              fin_cnt_nxt = fin_cnt_r + CNT_W'(1);
            end
          end
        end else begin
          now_nxt = TICK_W'(sel_res.nxt_arr);
        end
      end
      S_OSCAN: begin
        if (cmp_vld_r && cmp_last_r) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                = 1'b1;
          done_nxt[best_idx]           = 1'b0;
          out_data_nxt.job_number      = NUM_W'({1'b0, best_idx} + (IDX_W + 1)'(1));
          out_data_nxt.job_arrival     = sel_res.ent.arr;
          out_data_nxt.job_burst       = sel_res.ent.bur;
          out_data_nxt.completion_time = sel_res.ent.fin;
          out_data_nxt.turnaround_time = (tat_full > COMP_W'(TAT_SAT)) ?
                                         TAT_SAT : tat_full[TAT_W-1:0];
          out_data_nxt.waiting_time    = (wt_full > COMP_W'(TAT_SAT)) ?
                                         TAT_SAT : wt_full[TAT_W-1:0];
          out_data_nxt.last_result     = (fin_cnt_r + CNT_W'(1)) == cnt_r;
          if (out_data_nxt.last_result) begin
            state_nxt   = S_LOAD;
            cnt_nxt     = '0;
            now_nxt     = '0;
            fin_cnt_nxt = '0;
          end else begin
            state_nxt   = S_OSCAN;
            scan_nxt    = '0;
            iss_on_nxt  = 1'b1;
            fin_cnt_nxt = fin_cnt_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      fin_cnt_r   <= '0;
      scan_r      <= '0;
      iss_on_r    <= 1'b0;
      cmp_vld_r   <= 1'b0;
      cmp_last_r  <= 1'b0;
      now_r       <= '0;
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fin_cnt_r   <= fin_cnt_nxt;
      scan_r      <= scan_nxt;
      iss_on_r    <= iss_on_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      cmp_last_r  <= cmp_last_nxt;
      now_r       <= now_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r  <= cmp_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SRTF_ASSERT_IMPL(a_load_clean, state_r == S_LOAD, done_r == '0, "done flags left set while loading")
  `SRTF_ASSERT_IMPL(a_emit_pick, state_r == S_EMIT, sel_res.found, "no pending job found for a result")
  `SRTF_ASSERT(a_tick_adv, (state_r == S_UPD) |=> (now_r > $past(now_r)), "schedule clock did not advance")
  `SRTF_ASSERT(a_fin_bound, (fin_cnt_r <= cnt_r), "finished count exceeds loaded jobs")

endmodule

// File: verif/tb.sv
// Self-checking testbench for srtf_batch_scheduler_top: loads job batches and checks
// every reported job against a built-in shortest-remaining-time-first schedule (typed
// rows against the report in the row). Depends on srtf_pkg and the scheduler RTL only.
module tb;
  import srtf_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_JOBS = 250;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    in_item_t  job;
    bit        typed;
    out_item_t report;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  logic [ARR_W-1:0]  sched_arr  [MAX_PROC_DEF];
  logic [BUR_W-1:0]  sched_bur  [MAX_PROC_DEF];
  logic [BUR_W-1:0]  sched_rem  [MAX_PROC_DEF];
  logic [COMP_W-1:0] sched_fin  [MAX_PROC_DEF];
  bit                sched_done [MAX_PROC_DEF];
  int                sched_held;

  out_item_t job_reports[$];
  stim_row_t stim_rows[$];
  int        fail_count;
  int        jobs_sent;
  int        cycle_count;
  bit        idle_enabled;

  srtf_batch_scheduler_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Loads one job and, when it closes the batch, schedules the batch tick by tick.
  task automatic schedule_job(input in_item_t it);
    int        order [MAX_PROC_DEF];
    int        key, j, k, idx, finished, now, pick, comp, tat, wt;
    bit        found;
    int        best;
    out_item_t r;
    if (sched_held < MAX_PROC_DEF) begin
      sched_arr[sched_held]  = it.arrival_time;
      sched_bur[sched_held]  = (it.burst_time == '0) ? BUR_W'(1) : it.burst_time;
      sched_rem[sched_held]  = sched_bur[sched_held];
      sched_done[sched_held] = 1'b0;
      sched_held++;
    end
    if (!it.last_job) return;
    for (k = 0; k < sched_held; k++) order[k] = k;
    for (k = 1; k < sched_held; k++) begin
      key = order[k];
      j = k;
      while (j > 0 && sched_arr[order[j-1]] > sched_arr[key]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = key;
    end
    finished = 0;
    now = 0;
    while (finished < sched_held) begin
      found = 1'b0;
      pick = 0;
      best = 0;
      for (k = 0; k < sched_held; k++) begin
        idx = order[k];
        if (!sched_done[idx] && int'(sched_arr[idx]) <= now &&
            (!found || int'(sched_rem[idx]) < best)) begin
          found = 1'b1;
          best = int'(sched_rem[idx]);
          pick = idx;
        end
      end
      now++;
      if (found) begin
        sched_rem[pick] = sched_rem[pick] - BUR_W'(1);
        if (sched_rem[pick] == '0) begin
          sched_fin[pick] = COMP_W'(now);
          sched_done[pick] = 1'b1;
          finished++;
        end
      end
    end
    for (k = 0; k < sched_held; k++) begin
      idx = order[k];
      comp = int'(sched_fin[idx]);
      tat = (comp >= int'(sched_arr[idx])) ? comp - int'(sched_arr[idx]) : 0;
      wt = (tat >= int'(sched_bur[idx])) ? tat - int'(sched_bur[idx]) : 0;
      if (tat > int'(TAT_SAT)) tat = int'(TAT_SAT);
      if (wt > int'(TAT_SAT)) wt = int'(TAT_SAT);
      r.job_number      = NUM_W'(idx + 1);
      r.job_arrival     = sched_arr[idx];
      r.job_burst       = sched_bur[idx];
      r.completion_time = sched_fin[idx];
      r.turnaround_time = TAT_W'(tat);
      r.waiting_time    = TAT_W'(wt);
      r.last_result     = (k == sched_held - 1);
      job_reports.push_back(r);
    end
    sched_held = 0;
    for (k = 0; k < MAX_PROC_DEF; k++) sched_done[k] = 1'b0;
  endtask

  task automatic drive_item(input in_item_t it);
    while (idle_enabled && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    jobs_sent++;
    schedule_job(it);
  endtask

  task automatic add_row(input in_item_t job, input bit typed, input out_item_t report);
    stim_row_t row;
    row.job = job;
    row.typed = typed;
    row.report = report;
    stim_rows.push_back(row);
  endtask

  initial begin : stimulus
    int       r, n, batch_len, random_sent;
    bit       wide;
    in_item_t job;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    fail_count = 0;
    jobs_sent = 0;
    sched_held = 0;
    idle_enabled = 1'b1;
    for (n = 0; n < MAX_PROC_DEF; n++) sched_done[n] = 1'b0;

    add_row('{10'd0, 8'd0, 1'b1}, 1'b1, '{5'd1, 10'd0, 8'd1, 13'd1, 12'd1, 12'd0, 1'b1});
    add_row('{10'd1023, 8'd255, 1'b1}, 1'b1,
            '{5'd1, 10'd1023, 8'd255, 13'd1278, 12'd255, 12'd0, 1'b1});
    add_row('{10'd1023, 8'd0, 1'b1}, 1'b1,
            '{5'd1, 10'd1023, 8'd1, 13'd1024, 12'd1, 12'd0, 1'b1});
    add_row('{10'd3, 8'd8, 1'b0}, 1'b0, '0);
    add_row('{10'd0, 8'd5, 1'b0}, 1'b0, '0);
    add_row('{10'd0, 8'd5, 1'b0}, 1'b0, '0);
    add_row('{10'd1, 8'd2, 1'b0}, 1'b0, '0);
    add_row('{10'd2, 8'd0, 1'b0}, 1'b0, '0);
    add_row('{10'd40, 8'd3, 1'b0}, 1'b0, '0);
    add_row('{10'd40, 8'd3, 1'b0}, 1'b0, '0);
    add_row('{10'd41, 8'd1, 1'b0}, 1'b0, '0);
    add_row('{10'd600, 8'd255, 1'b0}, 1'b0, '0);
    add_row('{10'd600, 8'd200, 1'b0}, 1'b0, '0);
    add_row('{10'd605, 8'd1, 1'b0}, 1'b0, '0);
    add_row('{10'd1023, 8'd4, 1'b0}, 1'b0, '0);
    add_row('{10'd10, 8'd7, 1'b0}, 1'b0, '0);
    add_row('{10'd10, 8'd6, 1'b0}, 1'b0, '0);
    add_row('{10'd12, 8'd2, 1'b0}, 1'b0, '0);
    add_row('{10'd700, 8'd10, 1'b0}, 1'b0, '0);
    // The batch is full here, so this item is dropped but still starts the schedule.
    add_row('{10'd0, 8'd0, 1'b1}, 1'b0, '0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      drive_item(stim_rows[i].job);
      if (stim_rows[i].typed) begin
        void'(job_reports.pop_back());
        job_reports.push_back(stim_rows[i].report);
      end
    end

    random_sent = 0;
    while (random_sent < RANDOM_JOBS) begin
      r = $urandom_range(0, 99);
      if (r < 55) batch_len = $urandom_range(1, 4);
      else if (r < 80) batch_len = $urandom_range(5, 12);
      else if (r < 92) batch_len = MAX_PROC_DEF;
      else batch_len = $urandom_range(MAX_PROC_DEF + 1, MAX_PROC_DEF + 4);
      wide = ($urandom_range(0, 2) == 0);
      for (n = 0; n < batch_len; n++) begin
        idle_enabled = !(random_sent >= 100 && random_sent < 160);
        if (wide) begin
          job.arrival_time = ARR_W'($urandom_range(0, ARR_SPAN - 1));
          job.burst_time   = BUR_W'($urandom_range(0, BURST_MAX));
        end else begin
          job.arrival_time = ARR_W'($urandom_range(0, 31));
          job.burst_time   = BUR_W'($urandom_range(0, 15));
        end
        job.last_job = (n == batch_len - 1);
        drive_item(job);
        random_sent++;
      end
    end
    in_valid <= 1'b0;
    idle_enabled = 1'b1;

    while (job_reports.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // The receiver stalls at random, and once holds off long enough to back up the input.
  initial begin : receiver
    bit held_off;
    held_off = 1'b0;
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && jobs_sent >= 60) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= idle_enabled && ($urandom_range(0, 99) < 36);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (job_reports.size() == 0) begin
        $error("unexpected result item for job %0d", out_data.job_number);
        fail_count++;
      end else begin
        want = job_reports.pop_front();
        if (out_data.job_number !== want.job_number) begin
          $error("job_number: expected %0d, got %0d", want.job_number, out_data.job_number);
          fail_count++;
        end
        if (out_data.job_arrival !== want.job_arrival) begin
          $error("job_arrival: expected %0d, got %0d", want.job_arrival, out_data.job_arrival);
          fail_count++;
        end
        if (out_data.job_burst !== want.job_burst) begin
          $error("job_burst: expected %0d, got %0d", want.job_burst, out_data.job_burst);
          fail_count++;
        end
        if (out_data.completion_time !== want.completion_time) begin
          $error("completion_time: expected %0d, got %0d",
                 want.completion_time, out_data.completion_time);
          fail_count++;
        end
        if (out_data.turnaround_time !== want.turnaround_time) begin
          $error("turnaround_time: expected %0d, got %0d",
                 want.turnaround_time, out_data.turnaround_time);
          fail_count++;
        end
        if (out_data.waiting_time !== want.waiting_time) begin
          $error("waiting_time: expected %0d, got %0d",
                 want.waiting_time, out_data.waiting_time);
          fail_count++;
        end
        if (out_data.last_result !== want.last_result) begin
          $error("last_result: expected %0d, got %0d", want.last_result, out_data.last_result);
          fail_count++;
        end
      end
    end
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/srtf_pkg.sv
rtl/core/srtf_mem.sv
rtl/core/srtf_sel.sv
rtl/core/srtf_batch_scheduler_top.sv
verif/tb.sv
